// ----- rtl/core/tli_pkg.sv -----
package tli_pkg;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_FORWARD = 2'd1;
  localparam logic [1:0] CMD_REVERSE = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FLAT = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_SECOND,
    S_RD_LAST,
    S_ENDS,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FETCH_LO,
    S_FETCH_HI,
    S_FETCH_DONE,
    S_DIFF,
    S_MUL,
    S_DIV_INIT,
    S_DIV,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    RD_FIRST,
    RD_SECOND,
    RD_LAST,
    RD_SEG,
    RD_SEG_NEXT
  } rd_addr_e;

  typedef struct packed {
    logic     latch;
    rd_addr_e rd_addr;
    logic     cap_first;
    logic     cap_dir;
    logic     ends;
    logic     seg_dec;
    logic     cap_lo;
    logic     cap_hi;
    logic     diff;
    logic     mul;
    logic     div_init;
    logic     div_step;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic ends_hit;
    logic seg_zero;
    logic scan_hit;
    logic flat;
    logic overflow;
    logic div_last;
  } dp_stat_t;

endpackage

// ----- rtl/core/tli_ctrl.sv -----
module tli_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  output tli_pkg::dp_cmd_t   cmd_o,
  input  tli_pkg::dp_stat_t  stat_i
);

  tli_pkg::state_e state_q, state_d;

  assign busy = (state_q != tli_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tli_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_addr = tli_pkg::RD_FIRST;
    state_d       = state_q;
    case (state_q)
      tli_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          if (command_i == tli_pkg::CMD_FORWARD || command_i == tli_pkg::CMD_REVERSE) begin
            state_d = tli_pkg::S_RD_FIRST;
          end else begin
            state_d = tli_pkg::S_OUT;
          end
        end
      end
      tli_pkg::S_RD_FIRST: begin
        cmd_o.rd_addr = tli_pkg::RD_FIRST;
        state_d       = tli_pkg::S_RD_SECOND;
      end
      tli_pkg::S_RD_SECOND: begin
        cmd_o.rd_addr   = tli_pkg::RD_SECOND;
        cmd_o.cap_first = 1'b1;
        state_d         = tli_pkg::S_RD_LAST;
      end
      tli_pkg::S_RD_LAST: begin
        cmd_o.rd_addr = tli_pkg::RD_LAST;
        cmd_o.cap_dir = 1'b1;
        state_d       = tli_pkg::S_ENDS;
      end
      tli_pkg::S_ENDS: begin
        cmd_o.ends = 1'b1;
        state_d    = stat_i.ends_hit ? tli_pkg::S_FETCH_LO : tli_pkg::S_SCAN_RD;
      end
      tli_pkg::S_SCAN_RD: begin
        cmd_o.rd_addr = tli_pkg::RD_SEG;
        state_d       = stat_i.seg_zero ? tli_pkg::S_FETCH_LO : tli_pkg::S_SCAN_CMP;
      end
      tli_pkg::S_SCAN_CMP: begin
        if (stat_i.scan_hit) begin
          state_d = tli_pkg::S_FETCH_LO;
        end else begin
          cmd_o.seg_dec = 1'b1;
          state_d       = tli_pkg::S_SCAN_RD;
        end
      end
      tli_pkg::S_FETCH_LO: begin
        cmd_o.rd_addr = tli_pkg::RD_SEG;
        state_d       = tli_pkg::S_FETCH_HI;
      end
      tli_pkg::S_FETCH_HI: begin
        cmd_o.rd_addr = tli_pkg::RD_SEG_NEXT;
        cmd_o.cap_lo  = 1'b1;
        state_d       = tli_pkg::S_FETCH_DONE;
      end
      tli_pkg::S_FETCH_DONE: begin
        cmd_o.cap_hi = 1'b1;
        state_d      = tli_pkg::S_DIFF;
      end
      tli_pkg::S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = tli_pkg::S_MUL;
      end
      tli_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = stat_i.flat ? tli_pkg::S_OUT : tli_pkg::S_DIV_INIT;
      end
      tli_pkg::S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = stat_i.overflow ? tli_pkg::S_OUT : tli_pkg::S_DIV;
      end
      tli_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = tli_pkg::S_OUT;
        end
      end
      tli_pkg::S_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = tli_pkg::S_IDLE;
      end
      default: begin
        state_d = tli_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_write_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == tli_pkg::CMD_WRITE |=> state_q == tli_pkg::S_OUT)
    else $error("table write did not go straight to the result");

  a_div_stay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tli_pkg::S_DIV && !stat_i.div_last |=> state_q == tli_pkg::S_DIV)
    else $error("division left before its last step");

endmodule

// ----- rtl/core/tli_datapath.sv -----
module tli_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          command_i,
  input  logic [3:0]          entry_index_i,
  input  logic signed [31:0]  entry_x_i,
  input  logic signed [31:0]  entry_y_i,
  input  logic signed [31:0]  query_value_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i,
  input  tli_pkg::dp_cmd_t    cmd_i,
  output tli_pkg::dp_stat_t   stat_o,
  output logic                result_valid_o,
  output logic signed [31:0]  result_value_o,
  output logic [3:0]          segment_index_o,
  output logic [1:0]          status_o
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = (AW > 4) ? AW : 4;
  localparam int NW = (AW > 5) ? AW : 5;
  localparam logic signed [34:0] SUM_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SUM_MIN = -35'sd2147483648;

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] t;
    t = v[32] ? (~v + 33'd1) : v;
    return t[31:0];
  endfunction

  logic signed [31:0] x_mem [MAX_ENTRIES];
  logic signed [31:0] y_mem [MAX_ENTRIES];
  logic signed [31:0] rd_x_q, rd_y_q;

  logic [4:0]         count_q;
  logic               lookup_q, reverse_q, result_valid_q;
  logic signed [31:0] query_q, c0_q, a0_q, b0_q, a1_q, b1_q;
  logic               rising_q, neg_q, flat_q, ovf_q;
  logic [AW-1:0]      seg_q;
  logic [31:0]        mq_q, mb_q, ma_q;
  logic [63:0]        prod_q;
  logic [31:0]        rem_q;
  logic [32:0]        dvd_q, quo_q;
  logic [tli_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic signed [31:0] result_q;
  logic [3:0]         seg_out_q;
  logic [1:0]         status_q;

  logic               we;
  logic [CW-1:0]      slot_cw, seg_cw;
  logic [AW-1:0]      wr_addr, rd_addr, last, last_m1;
  logic [NW-1:0]      cnt_n, last_n;
  logic signed [31:0] col, other;
  logic               q_le_first, q_ge_first, q_le_last, q_ge_last, ends_low;
  logic signed [32:0] dq, db, da;
  logic [63:0]        prod_d;
  logic [32:0]        rem_sh, rem_sub;
  logic               div_ge, quo_big;
  logic signed [34:0] quo_s, sum;

  assign cfg_ready_o = 1'b1;

  assign slot_cw = CW'(entry_index_i);
  assign wr_addr = slot_cw[AW-1:0];
  assign we      = cmd_i.latch && (command_i == tli_pkg::CMD_WRITE) &&
                   (32'(entry_index_i) < 32'(MAX_ENTRIES));

  assign cnt_n  = NW'(count_q);
  assign last_n = (cnt_n < NW'(2)) ? NW'(1) :
                  (32'(count_q) > 32'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES - 1) :
                  cnt_n - NW'(1);
  assign last    = last_n[AW-1:0];
  assign last_m1 = last - AW'(1);

  always_comb begin
    case (cmd_i.rd_addr)
      tli_pkg::RD_FIRST:    rd_addr = '0;
      tli_pkg::RD_SECOND:   rd_addr = AW'(1);
      tli_pkg::RD_LAST:     rd_addr = last;
      tli_pkg::RD_SEG:      rd_addr = seg_q;
      tli_pkg::RD_SEG_NEXT: rd_addr = seg_q + AW'(1);
      default:              rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      x_mem[wr_addr] <= entry_x_i;
      y_mem[wr_addr] <= entry_y_i;
    end
    rd_x_q <= x_mem[rd_addr];
    rd_y_q <= y_mem[rd_addr];
  end

  assign col   = reverse_q ? rd_y_q : rd_x_q;
  assign other = reverse_q ? rd_x_q : rd_y_q;

  assign q_le_first = (query_q <= c0_q);
  assign q_ge_first = (query_q >= c0_q);
  assign q_le_last  = (query_q <= col);
  assign q_ge_last  = (query_q >= col);
  assign ends_low   = rising_q ? q_le_first : !q_le_last;

  assign dq = 33'(query_q) - 33'(a0_q);
  assign db = 33'(b1_q) - 33'(b0_q);
  assign da = 33'(a1_q) - 33'(a0_q);

  assign prod_d = 64'(mq_q) * 64'(mb_q);

  assign rem_sh  = {rem_q, dvd_q[32]};
  assign div_ge  = (rem_sh >= {1'b0, ma_q});
  assign rem_sub = rem_sh - {1'b0, ma_q};

  assign quo_big = quo_q[32] && (quo_q[31:0] != 32'd0);
  assign quo_s   = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign sum     = quo_s + 35'(b0_q);
  assign seg_cw  = CW'(seg_q);

  assign stat_o.ends_hit = rising_q ? (q_le_first || q_ge_last) : (q_le_last || q_ge_first);
  assign stat_o.seg_zero = (seg_q == '0);
  assign stat_o.scan_hit = rising_q ? q_ge_last : q_le_last;
  assign stat_o.flat     = flat_q;
  assign stat_o.overflow = ({1'b0, prod_q[63:33]} >= ma_q);
  assign stat_o.div_last = (div_cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= 5'd2;
      lookup_q       <= 1'b0;
      reverse_q      <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.emit;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.latch) begin
        lookup_q  <= (command_i == tli_pkg::CMD_FORWARD) ||
                     (command_i == tli_pkg::CMD_REVERSE);
        reverse_q <= (command_i == tli_pkg::CMD_REVERSE);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      query_q <= query_value_i;
    end
    if (cmd_i.cap_first) begin
      c0_q <= col;
    end
    if (cmd_i.cap_dir) begin
      rising_q <= !reverse_q || (c0_q < col);
    end
    if (cmd_i.ends) begin
      seg_q <= (stat_o.ends_hit && ends_low) ? '0 : last_m1;
    end else if (cmd_i.seg_dec) begin
      seg_q <= seg_q - AW'(1);
    end
    if (cmd_i.cap_lo) begin
      a0_q <= col;
      b0_q <= other;
    end
    if (cmd_i.cap_hi) begin
      a1_q <= col;
      b1_q <= other;
    end
    if (cmd_i.diff) begin
      mq_q   <= mag33(dq);
      mb_q   <= mag33(db);
      ma_q   <= mag33(da);
      neg_q  <= dq[32] ^ db[32] ^ da[32];
      flat_q <= (da == 33'sd0);
      ovf_q  <= 1'b0;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.div_init) begin
      ovf_q     <= stat_o.overflow;
      rem_q     <= {1'b0, prod_q[63:33]};
      dvd_q     <= prod_q[32:0];
      quo_q     <= '0;
      div_cnt_q <= tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1);
    end else if (cmd_i.div_step) begin
      rem_q     <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
      dvd_q     <= {dvd_q[31:0], 1'b0};
      quo_q     <= {quo_q[31:0], div_ge};
      div_cnt_q <= div_cnt_q - tli_pkg::DIV_CNT_W'(1);
    end
    if (cmd_i.emit) begin
      if (!lookup_q) begin
        result_q  <= '0;
        seg_out_q <= '0;
        status_q  <= tli_pkg::STATUS_OK;
      end else if (flat_q) begin
        result_q  <= '0;
        seg_out_q <= seg_cw[3:0];
        status_q  <= tli_pkg::STATUS_FLAT;
      end else if (ovf_q || quo_big) begin
        result_q  <= neg_q ? 32'sh80000000 : 32'sh7fffffff;
        seg_out_q <= seg_cw[3:0];
        status_q  <= tli_pkg::STATUS_SAT;
      end else if (sum > SUM_MAX) begin
        result_q  <= 32'sh7fffffff;
        seg_out_q <= seg_cw[3:0];
        status_q  <= tli_pkg::STATUS_SAT;
      end else if (sum < SUM_MIN) begin
        result_q  <= 32'sh80000000;
        seg_out_q <= seg_cw[3:0];
        status_q  <= tli_pkg::STATUS_SAT;
      end else begin
        result_q  <= sum[31:0];
        seg_out_q <= seg_cw[3:0];
        status_q  <= tli_pkg::STATUS_OK;
      end
    end
  end

  assign result_valid_o  = result_valid_q;
  assign result_value_o  = result_q;
  assign segment_index_o = seg_out_q;
  assign status_o        = status_q;

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q |=> !result_valid_q)
    else $error("result strobe held for more than one cycle");

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q && status_q == tli_pkg::STATUS_FLAT |-> result_q == 32'sd0)
    else $error("flat segment gave a nonzero result");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_q && status_q == tli_pkg::STATUS_SAT |->
      result_q == 32'sh7fffffff || result_q == 32'sh80000000)
    else $error("saturated result is not at a rail");

endmodule

// ----- rtl/core/table_linear_interpolator.sv -----
// Piecewise-linear table interpolator on signed Q16.16 breakpoints.
// An item is a command on command_i, taken at a clock edge with start high
// and busy low. Command write stores entry_x_i/entry_y_i in slot entry_index_i,
// forward maps query_value_i as x to y, reverse maps it as y to x.
// Every item gives one result transfer: result_valid_o is high for one cycle
// with result_value_o, segment_index_o and status_o, and cannot be held off.
// A write or an unused command goes straight to the result state. A lookup
// reads the first, second and last breakpoints, checks the query against the
// table ends and, between them, searches one breakpoint at a time from the
// top segment down to the first through the single-read table memory. It
// then fetches the segment, multiplies, and runs the 33-step restoring
// divider unless the segment is flat or the quotient is too large for 33 bits.
// Items are taken one at a time; busy drops in the cycle that the result is
// shown, so the next item may be accepted while it is delivered.
// entry_count is written on the cfg channel, which is always ready; the user
// must write it only while busy is low, as the block does not enforce that.
// Reset makes the block idle and sets entry_count to 2; the table holds no
// defined values until its slots are written.
module table_linear_interpolator #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command_i,
  input  logic [3:0]          entry_index_i,
  input  logic signed [31:0]  entry_x_i,
  input  logic signed [31:0]  entry_y_i,
  input  logic signed [31:0]  query_value_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i,
  output logic                result_valid_o,
  output logic signed [31:0]  result_value_o,
  output logic [3:0]          segment_index_o,
  output logic [1:0]          status_o
);

  tli_pkg::dp_cmd_t  dp_cmd;
  tli_pkg::dp_stat_t dp_stat;

  tli_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .cmd_o     (dp_cmd),
    .stat_i    (dp_stat)
  );

  tli_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .entry_x_i       (entry_x_i),
    .entry_y_i       (entry_y_i),
    .query_value_i   (query_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .result_valid_o  (result_valid_o),
    .result_value_o  (result_value_o),
    .segment_index_o (segment_index_o),
    .status_o        (status_o)
  );

endmodule

// ----- tb/table_linear_interpolator_checker.sv -----
`timescale 1ns / 100ps

module table_linear_interpolator_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         command_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] entry_x_i,
  input  logic signed [31:0] entry_y_i,
  input  logic signed [31:0] query_value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [4:0]         cfg_data_i,
  input  logic               result_valid_i,
  input  logic signed [31:0] result_value_i,
  input  logic [3:0]         segment_index_i,
  input  logic [1:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         segment;
    logic [1:0]         status;
  } lookup_result_t;

  localparam int TABLE_DEPTH = 16;
  localparam logic signed [31:0] I32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

  longint         x_tab [TABLE_DEPTH];
  longint         y_tab [TABLE_DEPTH];
  logic [4:0]     entry_count;
  lookup_result_t awaited_results [$];
  lookup_result_t oldest;
  lookup_result_t fresh;
  int             seg;
  int             live;
  int             slot;
  bit             falling;

  function automatic longint tab_at(input bit use_y, input int k);
    return use_y ? y_tab[k] : x_tab[k];
  endfunction

  function automatic int pick_segment(input bit use_y, input bit down, input int n,
                                      input longint q);
    int k;
    if (!down) begin
      if (q <= tab_at(use_y, 0)) return 0;
      if (q >= tab_at(use_y, n - 1)) return n - 2;
    end else begin
      if (q <= tab_at(use_y, n - 1)) return n - 2;
      if (q >= tab_at(use_y, 0)) return 0;
    end
    for (k = n - 1; k > 0; k--) begin
      if (down ? (q <= tab_at(use_y, k)) : (q >= tab_at(use_y, k))) break;
    end
    return k;
  endfunction

  function automatic lookup_result_t interpolate(input longint q, input longint a0,
                                                 input longint a1, input longint b0,
                                                 input longint b1, input int seg_lo);
    lookup_result_t r;
    longint         dq;
    longint         db;
    longint         da;
    longint         total;
    bit             neg;
    bit [63:0]      mq;
    bit [63:0]      mb;
    bit [63:0]      ma;
    bit [63:0]      quo;
    r.segment = seg_lo[3:0];
    r.status = tli_pkg::STATUS_OK;
    r.value = '0;
    dq = q - a0;
    db = b1 - b0;
    da = a1 - a0;
    if (da == 0) begin
      r.status = tli_pkg::STATUS_FLAT;
      return r;
    end
    neg = (dq < 0) ^ (db < 0) ^ (da < 0);
    mq = (dq < 0) ? -dq : dq;
    mb = (db < 0) ? -db : db;
    ma = (da < 0) ? -da : da;
    quo = (mq * mb) / ma;
    if (quo > 64'h1_0000_0000) begin
      r.status = tli_pkg::STATUS_SAT;
      r.value = neg ? I32_MIN : I32_MAX;
      return r;
    end
    total = neg ? b0 - $signed(quo) : b0 + $signed(quo);
    if (total > I32_MAX) begin
      r.status = tli_pkg::STATUS_SAT;
      r.value = I32_MAX;
    end else if (total < I32_MIN) begin
      r.status = tli_pkg::STATUS_SAT;
      r.value = I32_MIN;
    end else begin
      r.value = total[31:0];
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (slot = 0; slot < TABLE_DEPTH; slot++) begin
        x_tab[slot] = 0;
        y_tab[slot] = 0;
      end
      entry_count = 5'd2;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: unexpected result, value %0d, segment %0d, status %0d",
                   $time, result_value_i, segment_index_i, status_i);
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("result_value", oldest.value, result_value_i);
          compare_field("segment_index", {28'd0, oldest.segment}, {28'd0, segment_index_i});
          compare_field("status", {30'd0, oldest.status}, {30'd0, status_i});
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        entry_count = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        live = (entry_count < 2) ? 2 : (entry_count > TABLE_DEPTH) ? TABLE_DEPTH
                                                                    : int'(entry_count);
        fresh = '0;
        case (command_i)
          tli_pkg::CMD_WRITE: begin
            x_tab[entry_index_i] = longint'(entry_x_i);
            y_tab[entry_index_i] = longint'(entry_y_i);
          end
          tli_pkg::CMD_FORWARD: begin
            seg = pick_segment(1'b0, 1'b0, live, longint'(query_value_i));
            fresh = interpolate(longint'(query_value_i), x_tab[seg], x_tab[seg + 1],
                                y_tab[seg], y_tab[seg + 1], seg);
          end
          tli_pkg::CMD_REVERSE: begin
            // A y column that does not rise over its first two entries is searched as falling.
            falling = !(y_tab[0] < y_tab[1]);
            seg = pick_segment(1'b1, falling, live, longint'(query_value_i));
            fresh = interpolate(longint'(query_value_i), y_tab[seg], y_tab[seg + 1],
                                x_tab[seg], x_tab[seg + 1], seg);
          end
          default: begin
          end
        endcase
        awaited_results.push_back(fresh);
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- tb/table_linear_interpolator_tb.sv -----
`timescale 1ns / 100ps

module table_linear_interpolator_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = 16;
  localparam int ITEM_TARGET = 1100;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam longint I32_HIGH = 64'sd2147483647;
  localparam longint I32_LOW = -64'sd2147483648;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         command_i;
  logic [3:0]         entry_index_i;
  logic signed [31:0] entry_x_i;
  logic signed [31:0] entry_y_i;
  logic signed [31:0] query_value_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [4:0]         cfg_data_i;
  logic               result_valid_o;
  logic signed [31:0] result_value_o;
  logic [3:0]         segment_index_o;
  logic [1:0]         status_o;

  int     fail_count;
  int     pending;
  int     stall_cycles = 0;
  int     items_sent;
  int     live_n;
  bit     steady;
  longint tab_x [TABLE_DEPTH];
  longint tab_y [TABLE_DEPTH];

  always #6 clk_i = ~clk_i;

  table_linear_interpolator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .entry_x_i       (entry_x_i),
    .entry_y_i       (entry_y_i),
    .query_value_i   (query_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_valid_o  (result_valid_o),
    .result_value_o  (result_value_o),
    .segment_index_o (segment_index_o),
    .status_o        (status_o)
  );

  table_linear_interpolator_checker lookup_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .command_i       (command_i),
    .entry_index_i   (entry_index_i),
    .entry_x_i       (entry_x_i),
    .entry_y_i       (entry_y_i),
    .query_value_i   (query_value_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_valid_i  (result_valid_o),
    .result_value_i  (result_value_o),
    .segment_index_i (segment_index_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic longint rand_between(input longint lo, input longint hi);
    bit [63:0] span;
    bit [63:0] pick;
    span = hi - lo + 1;
    pick = {$urandom, $urandom};
    return lo + $signed(pick % span);
  endfunction

  function automatic longint rise_step(input int s);
    if ($urandom_range(0, 19) == 0) return 0;
    return longint'($urandom_range(1, 1 << s));
  endfunction

  function automatic logic [31:0] pick_query(input bit use_y);
    int     k;
    int     dice;
    longint lo;
    longint hi;
    longint q;
    longint mag;
    k = $urandom_range(0, live_n - 2);
    lo = use_y ? tab_y[k] : tab_x[k];
    hi = use_y ? tab_y[k + 1] : tab_x[k + 1];
    if (lo > hi) begin
      q = lo;
      lo = hi;
      hi = q;
    end
    dice = $urandom_range(0, 99);
    if (dice < 35) begin
      q = rand_between(lo, hi);
    end else if (dice < 50) begin
      q = $urandom_range(0, 1) ? lo : hi;
    end else if (dice < 70) begin
      k = $urandom_range(0, 1) ? 0 : live_n - 1;
      mag = 1;
      mag = mag << $urandom_range(0, 31);
      q = (use_y ? tab_y[k] : tab_x[k]) + rand_between(-mag, mag);
      if (q > I32_HIGH) q = I32_HIGH;
      if (q < I32_LOW) q = I32_LOW;
    end else begin
      q = longint'($signed($urandom));
    end
    return q[31:0];
  endfunction

  task automatic issue(input logic [1:0] cmd, input logic [3:0] slot,
                       input logic [31:0] ex, input logic [31:0] ey,
                       input logic [31:0] q);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 60);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    command_i = cmd;
    entry_index_i = slot;
    entry_x_i = ex;
    entry_y_i = ey;
    query_value_i = q;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  task automatic put_entry(input logic [3:0] slot, input longint x, input longint y);
    tab_x[slot] = x;
    tab_y[slot] = y;
    issue(tli_pkg::CMD_WRITE, slot, x[31:0], y[31:0], $urandom);
  endtask

  task automatic lookup(input bit use_y);
    issue(use_y ? tli_pkg::CMD_REVERSE : tli_pkg::CMD_FORWARD, 4'($urandom), $urandom,
          $urandom, pick_query(use_y));
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] value);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_table(input bit falling);
    int     s_x;
    int     s_y;
    int     k;
    longint x;
    longint y;
    longint room_x;
    longint room_y;
    s_x = $urandom_range(2, 27);
    s_y = $urandom_range(2, 27);
    room_x = 15;
    room_x = room_x << s_x;
    room_y = 15;
    room_y = room_y << s_y;
    x = rand_between(I32_LOW, I32_HIGH - room_x);
    y = falling ? rand_between(I32_LOW + room_y, I32_HIGH)
                : rand_between(I32_LOW, I32_HIGH - room_y);
    for (k = 0; k < live_n; k++) begin
      put_entry(k[3:0], x, y);
      x = x + rise_step(s_x);
      y = falling ? y - rise_step(s_y) : y + rise_step(s_y);
    end
  endtask

  initial begin
    int         phase;
    int         n_look;
    int         k;
    int         dice;
    logic [4:0] count_value;
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = tli_pkg::CMD_WRITE;
    entry_index_i = '0;
    entry_x_i = '0;
    entry_y_i = '0;
    query_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    steady = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The count register keeps its reset value of two entries here.
    live_n = 2;
    put_entry(4'd0, 64'sd0, 64'sd0);
    put_entry(4'd1, 64'sh1_0000, 64'sh2_0000);
    issue(tli_pkg::CMD_FORWARD, 4'd0, '0, '0, 32'h0000_8000);
    issue(tli_pkg::CMD_FORWARD, 4'd0, '0, '0, 32'h7fff_ffff);
    issue(tli_pkg::CMD_FORWARD, 4'd0, '0, '0, 32'h8000_0000);
    issue(tli_pkg::CMD_REVERSE, 4'd0, '0, '0, 32'h0001_0000);
    issue(tli_pkg::CMD_REVERSE, 4'd0, '0, '0, 32'h8000_0000);
    put_entry(4'd1, I32_HIGH, I32_LOW);
    put_entry(4'd0, I32_LOW, I32_HIGH);
    issue(tli_pkg::CMD_FORWARD, 4'd0, '1, '1, 32'h0000_0000);
    issue(tli_pkg::CMD_REVERSE, 4'd0, '1, '1, 32'h7fff_ffff);
    issue(tli_pkg::CMD_REVERSE, 4'd0, '1, '1, 32'h8000_0000);
    issue(tli_pkg::CMD_REVERSE, 4'd0, '1, '1, 32'h0000_0000);
    put_entry(4'd1, I32_LOW, I32_LOW);
    issue(tli_pkg::CMD_FORWARD, 4'd0, '0, '0, 32'h0000_0005);
    put_entry(4'd1, I32_LOW, I32_HIGH);
    issue(tli_pkg::CMD_REVERSE, 4'd0, '0, '0, 32'h0000_0000);
    issue(CMD_UNUSED, 4'hf, '1, '1, '1);
    put_entry(4'hf, I32_HIGH, I32_LOW);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: count_value = 5'd31;
        1: count_value = 5'd0;
        2: count_value = 5'd1;
        3: count_value = 5'd16;
        4: count_value = 5'd17;
        default: count_value = 5'($urandom_range(0, 31));
      endcase
      write_count(count_value);
      live_n = (count_value < 2) ? 2 : (count_value > TABLE_DEPTH) ? TABLE_DEPTH
                                                                    : int'(count_value);
      steady = (phase >= 5 && phase < 8);
      load_table($urandom_range(0, 1));
      n_look = $urandom_range(30, 70);
      for (k = 0; k < n_look; k++) begin
        dice = $urandom_range(0, 99);
        if (dice < 10) begin
          put_entry(4'($urandom), longint'($signed($urandom)),
                    longint'($signed($urandom)));
        end else if (dice < 15) begin
          issue(CMD_UNUSED, 4'($urandom), $urandom, $urandom, $urandom);
        end else begin
          lookup(dice >= 58);
        end
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
